>>> sv/adpcm_enc_pkg.sv
// Package for the ADPCM sample encoder: widths, limits, the step scale table,
// the sequencer state type and the request bundle for the shared adder.
// No dependencies.
package adpcm_enc_pkg;

  // Channel count and the width of a channel index.
  localparam int NUM_CHANNELS = 2;
  localparam int CHAN_W       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // Field and state widths.
  localparam int SAMPLE_W = 16;
  localparam int STEP_W   = 15;
  localparam int CODE_W   = 4;
  localparam int SCALE_W  = 10;

  // Width of the shared adder and accumulator; it holds the largest
  // product of step and scale entry with a sign bit to spare.
  localparam int ACC_W = 25;

  // Step size limits.
  localparam logic [STEP_W-1:0] STEP_MIN = STEP_W'(127);
  localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(24576);

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_ABS,
    ST_DIV,
    ST_MAG,
    ST_MULD,
    ST_LVL,
    ST_MULS,
    ST_DONE
  } state_t;

  // Request to the shared adder: result is a + b, or a - b when sub is set.
  typedef struct packed {
    logic [ACC_W-1:0] a;
    logic [ACC_W-1:0] b;
    logic             sub;
  } alu_req_t;

  // Step scale factor, in 1/256 units, chosen by the code magnitude.
  function automatic logic [SCALE_W-1:0] step_scale(input logic [2:0] mag);
    logic [SCALE_W-1:0] s;
    case (mag)
      3'd4:    s = SCALE_W'(10'h133);
      3'd5:    s = SCALE_W'(10'h199);
      3'd6:    s = SCALE_W'(10'h200);
      3'd7:    s = SCALE_W'(10'h266);
      default: s = SCALE_W'(10'h0e6);
    endcase
    return s;
  endfunction

endpackage

>>> sv/adpcm_enc_alu.sv
// Shared add/subtract unit of the ADPCM sample encoder.
// Depends on adpcm_enc_pkg for the request type and the adder width.
module adpcm_enc_alu import adpcm_enc_pkg::*; (
  input  alu_req_t         req,
  output logic [ACC_W-1:0] res
);

  // Two's complement subtraction inverts b and feeds the carry in.
  assign res = req.a + (req.sub ? ~req.b : req.b) + ACC_W'(req.sub);

endmodule

>>> sv/adpcm_sample_encoder_unit.sv
// ADPCM sample encoder: one 4-bit code per transaction, from a channel and a PCM sample.
// After input acceptance the sequencer steps through ERR, ABS, DIV, MAG, MULD, LVL, MULS
// and DONE, which registers the result and waits only while an earlier result is still
// stalled at the output. A new input is taken only in IDLE, after the last transaction,
// since a single shared adder performs the difference, its absolute value, a 5-step
// restoring division, two shift-add multiplies and the level update.
// A new input is taken while a finished result still waits at the output.
// Reset (synchronous) sets every predicted level to 0 and every step size to 127.
// Depends on adpcm_enc_pkg and adpcm_enc_alu.
module adpcm_sample_encoder_unit import adpcm_enc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [CHAN_W-1:0]          chan,
  input  logic signed [SAMPLE_W-1:0] pcm_sample,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [CODE_W-1:0]          code
);

  // Per-channel predictor state.
  logic signed [SAMPLE_W-1:0] level_mem [NUM_CHANNELS];
  logic [STEP_W-1:0]          step_mem  [NUM_CHANNELS];

  // Sequencer and datapath registers.
  state_t                     state, state_next;
  logic [CHAN_W-1:0]          chan_r, chan_r_next;
  logic signed [SAMPLE_W-1:0] x_r, x_r_next;
  logic signed [SAMPLE_W-1:0] level, level_next;
  logic [STEP_W-1:0]          step, step_next;
  logic [ACC_W-1:0]           acc, acc_next;
  logic [ACC_W-1:0]           mcand, mcand_next;
  logic [SCALE_W-1:0]         mreg, mreg_next;
  logic [4:0]                 qbits, qbits_next;
  logic [3:0]                 cnt, cnt_next;
  logic [2:0]                 mag, mag_next;
  logic                       err_neg, err_neg_next;
  logic                       sign_r, sign_r_next;
  logic [CODE_W-1:0]          code_next;
  logic                       out_valid_next;

  // Shared adder.
  alu_req_t         alu_req;
  logic [ACC_W-1:0] alu_res;

  // Miscellaneous combinational values.
  logic                    done_fire;
  logic [2:0]              mag_val;
  logic [STEP_W:0]         step_prod;
  logic [STEP_W-1:0]       step_new;
  logic [SAMPLE_W-1:0]     level_sat;
  logic [STEP_W-1:0]       step_rd;

  adpcm_enc_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  assign in_stall = (state != ST_IDLE);
  assign mag_val  = qbits[4] ? 3'd7 : qbits[3:1];
  assign step_rd  = step_mem[chan];

  // Level update saturates to the 16-bit range.
  always_comb begin
    if (alu_res[ACC_W-1:SAMPLE_W-1] == '0 || alu_res[ACC_W-1:SAMPLE_W-1] == '1) begin
      level_sat = alu_res[SAMPLE_W-1:0];
    end else if (alu_res[ACC_W-1]) begin
      level_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      level_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  // New step size: product shifted right by 8, clamped to its legal range.
  assign step_prod = acc[STEP_W+8:8];
  always_comb begin
    if (step_prod < {1'b0, STEP_MIN}) begin
      step_new = STEP_MIN;
    end else if (step_prod > {1'b0, STEP_MAX}) begin
      step_new = STEP_MAX;
    end else begin
      step_new = step_prod[STEP_W-1:0];
    end
  end

  // Operand selection for the shared adder.
  always_comb begin
    alu_req.a   = acc;
    alu_req.b   = '0;
    alu_req.sub = 1'b0;
    unique case (state)
      ST_ERR: begin
        alu_req.a   = ACC_W'(x_r);
        alu_req.b   = ACC_W'(level);
        alu_req.sub = 1'b1;
      end
      ST_ABS: begin
        alu_req.a   = acc[ACC_W-1] ? '0 : acc;
        alu_req.b   = acc[ACC_W-1] ? acc : '0;
        alu_req.sub = 1'b1;
      end
      ST_DIV: begin
        alu_req.a   = acc;
        alu_req.b   = ACC_W'(step) << cnt;
        alu_req.sub = 1'b1;
      end
      ST_MULD, ST_MULS: begin
        alu_req.a   = acc;
        alu_req.b   = mcand;
        alu_req.sub = 1'b0;
      end
      ST_LVL: begin
        alu_req.a   = ACC_W'(level);
        alu_req.b   = ACC_W'(acc[ACC_W-1:3]);
        alu_req.sub = sign_r;
      end
      default: begin
        alu_req.a   = acc;
        alu_req.b   = '0;
        alu_req.sub = 1'b0;
      end
    endcase
  end

  // Sequencer: next state and datapath updates.
  always_comb begin
    state_next     = state;
    chan_r_next    = chan_r;
    x_r_next       = x_r;
    level_next     = level;
    step_next      = step;
    acc_next       = acc;
    mcand_next     = mcand;
    mreg_next      = mreg;
    qbits_next     = qbits;
    cnt_next       = cnt;
    mag_next       = mag;
    err_neg_next   = err_neg;
    sign_r_next    = sign_r;
    code_next      = code;
    out_valid_next = out_valid && out_stall;
    done_fire      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          chan_r_next = chan;
          x_r_next    = pcm_sample;
          level_next  = level_mem[chan];
          step_next   = (step_rd == '0) ? STEP_MIN : step_rd;
          state_next  = ST_ERR;
        end
      end
      ST_ERR: begin
        acc_next   = alu_res;
        state_next = ST_ABS;
      end
      ST_ABS: begin
        err_neg_next = acc[ACC_W-1];
        acc_next     = {alu_res[ACC_W-4:0], 3'b000};
        qbits_next   = '0;
        cnt_next     = 4'd4;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        // Restoring division step: keep the difference when it is not negative.
        if (!alu_res[ACC_W-1]) begin
          acc_next = alu_res;
        end
        qbits_next[cnt[2:0]] = !alu_res[ACC_W-1];
        if (cnt == 4'd0) begin
          state_next = ST_MAG;
        end else begin
          cnt_next = cnt - 4'd1;
        end
      end
      ST_MAG: begin
        mag_next    = mag_val;
        sign_r_next = err_neg && (qbits != '0);
        mcand_next  = ACC_W'(step);
        mreg_next   = SCALE_W'({mag_val, 1'b1});
        acc_next    = '0;
        cnt_next    = 4'd3;
        state_next  = ST_MULD;
      end
      ST_MULD, ST_MULS: begin
        // Shift-add multiply, one multiplier bit a cycle.
        if (mreg[0]) begin
          acc_next = alu_res;
        end
        mcand_next = mcand << 1;
        mreg_next  = mreg >> 1;
        if (cnt == 4'd0) begin
          state_next = (state == ST_MULD) ? ST_LVL : ST_DONE;
        end else begin
          cnt_next = cnt - 4'd1;
        end
      end
      ST_LVL: begin
        level_next = level_sat;
        mcand_next = ACC_W'(step);
        mreg_next  = step_scale(mag);
        acc_next   = '0;
        cnt_next   = 4'(SCALE_W - 1);
        state_next = ST_MULS;
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          done_fire      = 1'b1;
          code_next      = {sign_r, mag};
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers and channel state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        level_mem[i] <= '0;
        step_mem[i]  <= STEP_MIN;
      end
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      if (done_fire) begin
        level_mem[chan_r] <= level;
        step_mem[chan_r]  <= step_new;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    chan_r  <= chan_r_next;
    x_r     <= x_r_next;
    level   <= level_next;
    step    <= step_next;
    acc     <= acc_next;
    mcand   <= mcand_next;
    mreg    <= mreg_next;
    qbits   <= qbits_next;
    cnt     <= cnt_next;
    mag     <= mag_next;
    err_neg <= err_neg_next;
    sign_r  <= sign_r_next;
    code    <= code_next;
  end

  // The division remainder never goes negative.
  a_rem_pos: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> !acc[ACC_W-1])
    else $error("division remainder went negative");

  // When the top quotient bit is clear, the final remainder is below the step.
  a_rem_lt_step: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MAG && !qbits[4]) |-> (acc < ACC_W'(step)))
    else $error("division remainder not below step size");

  // The stored step size of channel 0 stays within its legal range.
  a_step0_range: assert property (@(posedge clk) disable iff (rst)
    (step_mem[0] >= STEP_MIN) && (step_mem[0] <= STEP_MAX))
    else $error("channel 0 step size out of range");

  // Finishing a transaction always leaves a result at the output.
  a_done_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && state_next == ST_IDLE) |=> out_valid)
    else $error("finished transaction produced no result");

endmodule

>>> tb/sv/adpcm_sample_encoder_unit_tb.sv
// Self-checking testbench for the ADPCM sample encoder: drives channel and sample
// transactions, predicts every 4-bit code and compares it with the block's output.
// Depends on adpcm_enc_pkg and adpcm_sample_encoder_unit.
module adpcm_sample_encoder_unit_tb import adpcm_enc_pkg::*; ;

  // Keeps a copy of each channel's predictor and step size and the codes still owed.
  class adpcm_code_tracker;
    logic signed [SAMPLE_W-1:0] level [NUM_CHANNELS];
    logic [STEP_W-1:0]          step  [NUM_CHANNELS];
    logic [CODE_W-1:0]          code_q [$];
    int                         mismatches;
    int                         codes_checked;
    int                         samples_noted;

    function new();
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        level[i] = '0;
        step[i]  = STEP_MIN;
      end
      mismatches    = 0;
      codes_checked = 0;
      samples_noted = 0;
    endfunction

    // Scale factor in 1/256 units for a given code magnitude.
    function int scale_for(int mag);
      case (mag)
        4:       return 307;
        5:       return 409;
        6:       return 512;
        7:       return 614;
        default: return 230;
      endcase
    endfunction

    // Encodes one accepted sample and advances that channel's predictor.
    function void note_sample(logic [CHAN_W-1:0] ch, logic signed [SAMPLE_W-1:0] smp);
      int  idx;
      int  lvl;
      int  st;
      int  err;
      int  quo;
      int  mag;
      int  delta;
      int  nxt;
      bit  neg;
      idx = int'(ch) % NUM_CHANNELS;
      lvl = level[idx];
      st  = int'(step[idx]);
      if (st == 0) st = 127;
      err = int'(smp) - lvl;
      quo = (err * 8) / st;
      neg = quo < 0;
      mag = (neg ? -quo : quo) / 2;
      if (mag > 7) mag = 7;
      // Move the predicted level by the reconstructed difference, then saturate.
      delta = (st * (2 * mag + 1)) >> 3;
      lvl = neg ? lvl - delta : lvl + delta;
      if (lvl < -32768) lvl = -32768;
      if (lvl > 32767) lvl = 32767;
      // Adapt the step size and keep it within its limits.
      nxt = (st * scale_for(mag)) >> 8;
      if (nxt < 127) nxt = 127;
      if (nxt > 24576) nxt = 24576;
      level[idx] = lvl[SAMPLE_W-1:0];
      step[idx]  = nxt[STEP_W-1:0];
      code_q.push_back({neg, mag[2:0]});
      samples_noted++;
    endfunction

    // Compares one accepted code with the oldest prediction.
    function void check_code(logic [CODE_W-1:0] got);
      logic [CODE_W-1:0] want;
      if (code_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected code %0h with no transaction outstanding", got);
        return;
      end
      want = code_q.pop_front();
      codes_checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Code mismatch on result %0d: expected %0h, got %0h",
                   codes_checked, want, got);
      end
    endfunction

    function int pending();
      return code_q.size();
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 1600;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       in_valid;
  logic                       in_stall;
  logic [CHAN_W-1:0]          chan;
  logic signed [SAMPLE_W-1:0] pcm_sample;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [CODE_W-1:0]          code;

  adpcm_code_tracker tracker = new();
  bit                no_idle = 1'b0;
  int                idle_cycles = 0;

  adpcm_sample_encoder_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .chan       (chan),
    .pcm_sample (pcm_sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .code       (code)
  );

  always #5 clk = ~clk;

  // Sends one sample transaction, with random idle cycles ahead of it.
  task automatic send_sample(input logic [CHAN_W-1:0] ch,
                             input logic signed [SAMPLE_W-1:0] smp);
    while (!no_idle && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    chan       <= ch;
    pcm_sample <= smp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_sample(ch, smp);
  endtask

  // Random-walk waveform on random channels, with varying amplitude.
  task automatic send_waveform(input int count);
    int walk [NUM_CHANNELS];
    int span;
    int ch;
    for (int i = 0; i < NUM_CHANNELS; i++) walk[i] = $urandom_range(65535) - 32768;
    case ($urandom_range(3))
      0:       span = 64;
      1:       span = 1024;
      2:       span = 8192;
      default: span = 40000;
    endcase
    for (int n = 0; n < count; n++) begin
      ch = $urandom_range(NUM_CHANNELS - 1);
      walk[ch] += $urandom_range(2 * span) - span;
      if (walk[ch] > 32767) walk[ch] = 32767;
      if (walk[ch] < -32768) walk[ch] = -32768;
      send_sample(ch[CHAN_W-1:0], walk[ch][SAMPLE_W-1:0]);
    end
  endtask

  // Result side: checks accepted codes and stalls at random.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) tracker.check_code(code);
    out_stall <= !no_idle && ($urandom_range(99) < 31);
  end

  // Watchdog: counts cycles in which neither side completes a transaction.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d codes outstanding", tracker.pending());
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus: directed corner cases, then random waveforms, noise and silence.
  initial begin
    int sent;
    int seg;
    rst        = 1'b1;
    in_valid   = 1'b0;
    chan       = '0;
    pcm_sample = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zero error, then small negative errors that give a zero magnitude.
    send_sample(1'b0, 16'sd0);
    send_sample(1'b0, -16'sd1);
    send_sample(1'b0, -16'sd15);
    // Full-scale steps, positive then negative, make the step size grow and swing the level.
    repeat (4) send_sample(1'b0, 16'sh7fff);
    repeat (4) send_sample(1'b0, -16'sh8000);
    send_sample(1'b0, 16'sd0);
    // Second channel from reset, interleaved with the first.
    send_sample(1'b1, -16'sh8000);
    send_sample(1'b1, 16'sh7fff);
    send_sample(1'b0, 16'sh5555);
    send_sample(1'b1, 16'sd16);
    send_sample(1'b1, -16'sd1);
    send_sample(1'b0, 16'shaaaa);
    send_sample(1'b1, 16'sd0);
    repeat (3) send_sample(1'b1, 16'sd0);

    // Random part: mostly waveforms, some full-range noise and silence.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      no_idle = (sent >= 700 && sent < 1000);
      seg = $urandom_range(60, 20);
      case ($urandom_range(7))
        0: begin
          repeat (seg) send_sample(CHAN_W'($urandom_range(NUM_CHANNELS - 1)),
                                   SAMPLE_W'($urandom_range(65535)));
        end
        1: begin
          repeat (seg) send_sample(CHAN_W'($urandom_range(NUM_CHANNELS - 1)), 16'sd0);
        end
        default: send_waveform(seg);
      endcase
      sent += seg;
    end
    no_idle = 1'b0;
    in_valid <= 1'b0;

    // Drain, then keep watching the output before judging, so that any extra code is caught.
    while (tracker.pending() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("Encoded %0d samples on %0d channels (corner cases, waveforms, noise, silence);",
             tracker.samples_noted, NUM_CHANNELS);
    $display("compared %0d codes, %0d mismatches, %0d left outstanding.",
             tracker.codes_checked, tracker.mismatches, tracker.pending());
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
